/* hdl/fpn_pkg.sv */
// Shared types, constants and arithmetic helpers for the fractal Perlin noise block.
`default_nettype none

package fpn_pkg;

    localparam int TABLE_SIZE      = 256;
    localparam int PERM_W          = 8;
    localparam int DEF_MAX_OCTAVES = 8;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int OUT_W           = 16;

    localparam logic KIND_PERM  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [7:0]         perm_index;
        logic [7:0]         perm_value;
        logic signed [31:0] x_pos;
        logic signed [31:0] z_pos;
        logic [3:0]         octave_count;
    } t_in_item;

    typedef struct packed {
        logic [15:0] noise_value;
        logic        clipped;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OCT,
        S_CHK,
        S_DIV,
        S_DONE
    } t_state;

    // Micro-steps of one octave
    typedef enum logic [3:0] {
        ST_TT_X,
        ST_T3_X,
        ST_F_X,
        ST_TT_Z,
        ST_T3_Z,
        ST_F_Z,
        ST_CAP_Z,
        ST_LX1,
        ST_LX2,
        ST_KEEP_X2,
        ST_LR,
        ST_ACC
    } t_step;

    typedef logic signed [18:0] t_gval;

    // q = (6t^2 + 10*2^32 - 15t*2^16) >> 16, tt = t*t
    function automatic logic [19:0] fade_q(input logic [31:0] tt, input logic [15:0] t);
        logic [39:0] s;
        logic [19:0] t15;
        t15 = {t, 4'b0} - {4'b0, t};
        s   = ({8'b0, tt} << 2) + ({8'b0, tt} << 1) + (40'd10 << 32) - ({20'b0, t15} << 16);
        return s[35:16];
    endfunction

    function automatic logic [16:0] fade_cap(input logic [20:0] f);
        if (f > 21'd65536) begin
            return 17'd65536;
        end
        return f[16:0];
    endfunction

    function automatic t_gval grad(input logic [1:0] h, input t_gval x, input t_gval z);
        t_gval g;
        case (h)
            2'd0:    g = x + z;
            2'd1:    g = z - x;
            2'd2:    g = x - z;
            default: g = -x - z;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

/* hdl/fpn_stream_if.sv */
// Valid/ready stream channel carrying one payload beat.
`default_nettype none

interface fpn_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/fractal_perlin_noise_2d.sv */
// Fractal 2-D Perlin noise: top level, octave sequencer, shared multiplier and divider.
// Usage:
//   i_in_ch carries one beat per item. kind = KIND_PERM writes perm_value into
//   permutation entry perm_index and yields no result.
//   kind = KIND_QUERY samples noise at (x_pos, z_pos), Q16.16 by default, summed
//   over octave_count octaves (0 counts as 1, large counts clamp to MAX_OCTAVES).
//   o_out_ch returns one beat per query: noise_value (Q0.16) and clipped.
// Sequence:
//   A query runs each octave's micro-steps through one 21x21 multiplier and the
//   permutation RAM read port, then a check state, then a restoring divider
//   for the 16-bit quotient (skipped when the result saturates), then a done
//   state that hands over the result. ready is high only while the sequencer
//   is idle.
// Reset:
//   The permutation table reads as identity after reset; each entry carries a
//   valid flag that is set when it is written, so no clearing pass is needed.
// Stalls:
//   The result sits in an output register; the block goes idle and takes new
//   beats while it waits, and a following query holds at its end until taken.
`default_nettype none

module fractal_perlin_noise_2d import fpn_pkg::*; #(
    parameter int MAX_OCTAVES = DEF_MAX_OCTAVES,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    fpn_stream_if.sink   i_in_ch,
    fpn_stream_if.source o_out_ch
);
    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
    localparam int ACC_W = MAX_OCTAVES + 21;
    localparam int IDX_W = $clog2(TABLE_SIZE);

    t_state r_state, n_state;
    t_step  r_step;

    logic [OCT_W-1:0]        r_oct, r_oct_i;
    logic [31:0]             r_cx, r_cz;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [41:0]      r_prod;
    logic [19:0]             r_q;
    logic [16:0]             r_u, r_w;
    logic [PERM_W-1:0]       r_p0, r_p1, r_h_aa, r_h_ab, r_h_ba, r_h_bb;
    t_gval                   r_x1, r_x2;
    logic [ACC_W-1:0]        r_rem, r_dsh;
    logic [15:0]             r_quo;
    logic [3:0]              r_bit;
    logic [OUT_W-1:0]        r_res_noise;
    logic                    r_res_clip;
    logic                    r_out_valid;
    t_out_item               r_out;
    logic [TABLE_SIZE-1:0]   r_pvalid;
    logic                    r_rvalid;
    logic [IDX_W-1:0]        r_raddr;

    logic                    w_accept, w_we, w_last_oct, w_ge, w_out_free;
    logic [IDX_W-1:0]        w_raddr, w_xi, w_zi;
    logic [PERM_W-1:0]       w_ram_q, w_rd;
    logic [15:0]             w_xf, w_zf;
    logic signed [20:0]      w_ma, w_mb, w_lerp, w_r, w_n;
    logic signed [41:0]      w_prod;
    t_gval                   w_x0, w_x1, w_z0, w_z1, w_g_aa, w_g_ab, w_g_ba, w_g_bb;
    logic [ACC_W-1:0]        w_den, w_top;
    logic [OCT_W-1:0]        w_oct_in;
    logic signed [ACC_W-1:0] w_acc_next;

    // Coordinate fraction rescaled to 16 bits
    generate
        if (FRAC_BITS >= 16) begin : g_frac_shr
            assign w_xf = r_cx[FRAC_BITS-1 -: 16];
            assign w_zf = r_cz[FRAC_BITS-1 -: 16];
        end else begin : g_frac_shl
            assign w_xf = {r_cx[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
            assign w_zf = {r_cz[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
        end
    endgenerate

    assign w_xi = r_cx[FRAC_BITS +: IDX_W];
    assign w_zi = r_cz[FRAC_BITS +: IDX_W];

    assign w_x0 = $signed({3'b0, w_xf});
    assign w_z0 = $signed({3'b0, w_zf});
    assign w_x1 = w_x0 - 19'sd65536;
    assign w_z1 = w_z0 - 19'sd65536;

    assign w_g_aa = grad(r_h_aa[1:0], w_x0, w_z0);
    assign w_g_ab = grad(r_h_ab[1:0], w_x0, w_z1);
    assign w_g_ba = grad(r_h_ba[1:0], w_x1, w_z0);
    assign w_g_bb = grad(r_h_bb[1:0], w_x1, w_z1);

    // floor(t*(b-a) / 2^16); only the low bits matter as the sum stays small
    assign w_lerp     = $signed(r_prod[36:16]);
    assign w_r        = 21'(r_x1) + w_lerp;
    assign w_n        = (w_r + 21'sd65536) >>> 1;
    assign w_acc_next = (r_acc <<< 1) + ACC_W'(w_n);

    assign w_prod = w_ma * w_mb;

    assign w_den  = ACC_W'((ACC_W'(1) << r_oct) - ACC_W'(1));
    assign w_top  = w_den << 16;
    assign w_ge   = r_rem >= r_dsh;

    assign w_last_oct = (OCT_W'(r_oct_i + 1'b1) == r_oct);
    assign w_accept   = i_in_ch.valid && i_in_ch.ready;
    assign w_we       = w_accept && (i_in_ch.payload.kind == KIND_PERM);
    assign w_out_free = !r_out_valid || o_out_ch.ready;

    always_comb begin
        if (i_in_ch.payload.octave_count == 4'd0) begin
            w_oct_in = OCT_W'(1);
        end else if (int'(i_in_ch.payload.octave_count) > MAX_OCTAVES) begin
            w_oct_in = OCT_W'(MAX_OCTAVES);
        end else begin
            w_oct_in = OCT_W'(i_in_ch.payload.octave_count);
        end
    end

    fpn_ram #(
        .WIDTH (PERM_W),
        .DEPTH (TABLE_SIZE)
    ) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_in_ch.payload.perm_index),
        .i_wdata (i_in_ch.payload.perm_value),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    // Unwritten entries read as identity
    assign w_rd = r_rvalid ? w_ram_q : r_raddr;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_in_ch.payload.kind == KIND_QUERY) begin
                    n_state = S_OCT;
                end
            end
            S_OCT: begin
                if (r_step == ST_ACC && w_last_oct) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_acc < 0 || $unsigned(r_acc) >= w_top) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_bit == 4'd0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: handshake, RAM address and multiplier operands
    always_comb begin
        i_in_ch.ready = (r_state == S_IDLE);
        w_raddr       = '0;
        w_ma          = '0;
        w_mb          = '0;
        if (r_state == S_OCT) begin
            case (r_step)
                ST_TT_X: begin
                    w_raddr = w_xi;
                    w_ma    = $signed({5'b0, w_xf});
                    w_mb    = $signed({5'b0, w_xf});
                end
                ST_T3_X: begin
                    w_raddr = IDX_W'(w_xi + 1'b1);
                    w_ma    = $signed({5'b0, r_prod[31:16]});
                    w_mb    = $signed({5'b0, w_xf});
                end
                ST_F_X: begin
                    w_raddr = IDX_W'(r_p0 + w_zi);
                    w_ma    = $signed({5'b0, r_prod[31:16]});
                    w_mb    = $signed({1'b0, r_q});
                end
                ST_TT_Z: begin
                    w_raddr = IDX_W'(r_p0 + w_zi + 1'b1);
                    w_ma    = $signed({5'b0, w_zf});
                    w_mb    = $signed({5'b0, w_zf});
                end
                ST_T3_Z: begin
                    w_raddr = IDX_W'(r_p1 + w_zi);
                    w_ma    = $signed({5'b0, r_prod[31:16]});
                    w_mb    = $signed({5'b0, w_zf});
                end
                ST_F_Z: begin
                    w_raddr = IDX_W'(r_p1 + w_zi + 1'b1);
                    w_ma    = $signed({5'b0, r_prod[31:16]});
                    w_mb    = $signed({1'b0, r_q});
                end
                ST_LX1: begin
                    w_ma = $signed({4'b0, r_u});
                    w_mb = 21'(w_g_ba) - 21'(w_g_aa);
                end
                ST_LX2: begin
                    w_ma = $signed({4'b0, r_u});
                    w_mb = 21'(w_g_bb) - 21'(w_g_ab);
                end
                ST_LR: begin
                    w_ma = $signed({4'b0, r_w});
                    w_mb = 21'(r_x2) - 21'(r_x1);
                end
                default: begin
                    w_ma = '0;
                end
            endcase
        end
    end

    assign o_out_ch.valid   = r_out_valid;
    assign o_out_ch.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_TT_X;
            r_out_valid <= 1'b0;
            r_pvalid    <= '0;
        end else begin
            r_state <= n_state;
            if (w_we) begin
                r_pvalid[i_in_ch.payload.perm_index] <= 1'b1;
            end
            if (r_state == S_OCT) begin
                if (r_step == ST_ACC) begin
                    r_step <= ST_TT_X;
                end else begin
                    r_step <= t_step'(r_step + 1'b1);
                end
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_prod   <= w_prod;
        r_raddr  <= w_raddr;
        r_rvalid <= r_pvalid[w_raddr];
        case (r_state)
            S_IDLE: begin
                r_cx    <= i_in_ch.payload.x_pos;
                r_cz    <= i_in_ch.payload.z_pos;
                r_oct   <= w_oct_in;
                r_oct_i <= '0;
                r_acc   <= '0;
            end
            S_OCT: begin
                case (r_step)
                    ST_T3_X: begin
                        r_p0 <= w_rd;
                        r_q  <= fade_q(r_prod[31:0], w_xf);
                    end
                    ST_F_X:   r_p1   <= w_rd;
                    ST_TT_Z: begin
                        r_h_aa <= w_rd;
                        r_u    <= fade_cap(r_prod[36:16]);
                    end
                    ST_T3_Z: begin
                        r_h_ab <= w_rd;
                        r_q    <= fade_q(r_prod[31:0], w_zf);
                    end
                    ST_F_Z:   r_h_ba <= w_rd;
                    ST_CAP_Z: r_h_bb <= w_rd;
                    ST_LX2:   r_x1   <= t_gval'(21'(w_g_aa) + w_lerp);
                    ST_KEEP_X2: begin
                        r_x2 <= t_gval'(21'(w_g_ab) + w_lerp);
                    end
                    ST_ACC: begin
                        r_acc   <= w_acc_next;
                        r_cx    <= r_cx << 1;
                        r_cz    <= r_cz << 1;
                        r_oct_i <= OCT_W'(r_oct_i + 1'b1);
                    end
                    default: begin
                        r_p0 <= r_p0;
                    end
                endcase
                // second fade result is registered in ST_CAP_Z, the step that captures the last hash read
                if (r_step == ST_CAP_Z) begin
                    r_w <= fade_cap(r_prod[36:16]);
                end
            end
            S_CHK: begin
                r_rem <= $unsigned(r_acc);
                r_dsh <= w_den << 15;
                r_bit <= 4'd15;
                r_quo <= '0;
                if (r_acc < 0) begin
                    r_res_noise <= '0;
                    r_res_clip  <= 1'b1;
                end else begin
                    r_res_noise <= '1;
                    r_res_clip  <= 1'b1;
                end
            end
            S_DIV: begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh <= r_dsh >> 1;
                r_quo <= {r_quo[14:0], w_ge};
                r_bit <= r_bit - 1'b1;
                if (r_bit == 4'd0) begin
                    r_res_noise <= {r_quo[14:0], w_ge};
                    r_res_clip  <= 1'b0;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out.noise_value <= r_res_noise;
                    r_out.clipped     <= r_res_clip;
                end
            end
            default: begin
                r_bit <= r_bit;
            end
        endcase
    end

    a_perm_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> r_pvalid[$past(i_in_ch.payload.perm_index)])
        else $error("written permutation entry not marked valid");

    a_oct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OCT) |-> (r_oct_i < r_oct))
        else $error("octave index beyond octave count");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < (r_dsh << 1)))
        else $error("divider remainder out of range");

    a_clip_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.payload.clipped) |->
        (o_out_ch.payload.noise_value == 16'h0000 || o_out_ch.payload.noise_value == 16'hFFFF))
        else $error("clipped result not at a range end");

endmodule

`default_nettype wire

/* hdl/fpn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fpn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

/* tb/sv/fractal_perlin_noise_2d_tb.sv */
// Self-checking testbench for the fractal 2-D Perlin noise block.
`default_nettype none

module fractal_perlin_noise_2d_tb;
    import fpn_pkg::*;

    // Golden noise predictor and queue of pending expected samples.
    class noise_scoreboard;
        logic [7:0]  perm [TABLE_SIZE];
        t_out_item   pending [$];
        int          mismatches;
        int          samples_checked;

        function void load_identity();
            for (int i = 0; i < TABLE_SIZE; i++) begin
                perm[i] = i[7:0];
            end
        endfunction

        function longint floor_div2n(longint v, int s);
            return v >>> s;
        endfunction

        function longint fade(longint t);
            longint t3;
            longint q;
            longint f;
            t3 = (((t * t) >>> 16) * t) >>> 16;
            q  = (6 * t * t + (longint'(10) <<< 32) - ((15 * t) <<< 16)) >>> 16;
            f  = (t3 * q) >>> 16;
            if (f > 65536) begin
                f = 65536;
            end
            return f;
        endfunction

        function longint gradient(logic [7:0] h, longint x, longint z);
            case (h[1:0])
                2'd0:    return x + z;
                2'd1:    return z - x;
                2'd2:    return x - z;
                default: return -x - z;
            endcase
        endfunction

        function longint blend(longint a, longint b, longint t);
            return a + floor_div2n(t * (b - a), 16);
        endfunction

        function longint octave_value(logic [31:0] cx, logic [31:0] cz);
            logic [7:0] xi;
            logic [7:0] zi;
            logic [7:0] p0;
            logic [7:0] p1;
            longint xf;
            longint zf;
            longint u;
            longint w;
            longint x1;
            longint x2;
            longint r;
            xi = cx[23:16];
            zi = cz[23:16];
            xf = longint'(cx[15:0]);
            zf = longint'(cz[15:0]);
            u  = fade(xf);
            w  = fade(zf);
            p0 = perm[xi];
            p1 = perm[8'(xi + 8'd1)];
            x1 = blend(gradient(perm[8'(p0 + zi)], xf, zf),
                       gradient(perm[8'(p1 + zi)], xf - 65536, zf), u);
            x2 = blend(gradient(perm[8'(p0 + zi + 8'd1)], xf, zf - 65536),
                       gradient(perm[8'(p1 + zi + 8'd1)], xf - 65536, zf - 65536), u);
            r  = blend(x1, x2, w);
            return floor_div2n(r + 65536, 1);
        endfunction

        // Note an accepted input beat: apply a table write or queue the sample.
        function void note_input(t_in_item it);
            int        oct;
            longint    acc;
            longint    den;
            longint    val;
            t_out_item res;
            if (it.kind == KIND_PERM) begin
                perm[it.perm_index] = it.perm_value;
                return;
            end
            oct = int'(it.octave_count);
            if (oct < 1) oct = 1;
            if (oct > DEF_MAX_OCTAVES) oct = DEF_MAX_OCTAVES;
            acc = 0;
            for (int i = 0; i < oct; i++) begin
                acc += octave_value(32'(it.x_pos << i), 32'(it.z_pos << i))
                       * (longint'(1) <<< (oct - 1 - i));
            end
            den = (longint'(1) <<< oct) - 1;
            if (acc >= 0) val = acc / den;
            else val = -((-acc + den - 1) / den);
            res.clipped = 1'b0;
            if (val < 0) begin
                val = 0;
                res.clipped = 1'b1;
            end else if (val > 65535) begin
                val = 65535;
                res.clipped = 1'b1;
            end
            res.noise_value = val[15:0];
            pending.push_back(res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_r;
            samples_checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected sample %h/%b", got.noise_value, got.clipped);
                return;
            end
            exp_r = pending.pop_front();
            if (got.noise_value !== exp_r.noise_value || got.clipped !== exp_r.clipped) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("sample %0d: expected noise %h clipped %b, got %h %b",
                             samples_checked, exp_r.noise_value, exp_r.clipped,
                             got.noise_value, got.clipped);
                end
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 1500000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fpn_stream_if #(.T(t_in_item))  in_ch ();
    fpn_stream_if #(.T(t_out_item)) out_ch ();

    fractal_perlin_noise_2d u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    noise_scoreboard board;
    int  cycles;
    int  beats_sent;
    int  queries_sent;
    int  perm_writes;
    bit  long_stall;
    bit  stall_done;

    always #6 i_clk = ~i_clk;

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("fractal_perlin_noise_2d_tb: errors");
            $finish;
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            board.note_input(in_ch.payload);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            board.check_result(out_ch.payload);
        end
    end

    // Receiver: random holds per beat, plus one long hold-off on request.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_stall && !stall_done) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                stall_done = 1'b1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // valid stays up between back-to-back beats; it drops only for an idle gap
    task automatic send_beat(t_in_item it, int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.payload <= it;
        in_ch.valid   <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        beats_sent++;
        if (it.kind == KIND_QUERY) queries_sent++;
        else perm_writes++;
    endtask

    function automatic t_in_item make_query(logic [31:0] x, logic [31:0] z, logic [3:0] oct);
        t_in_item it;
        it.kind         = KIND_QUERY;
        it.perm_index   = 8'($urandom());
        it.perm_value   = 8'($urandom());
        it.x_pos        = x;
        it.z_pos        = z;
        it.octave_count = oct;
        return it;
    endfunction

    function automatic t_in_item make_write(logic [7:0] idx, logic [7:0] val);
        t_in_item it;
        it.kind         = KIND_PERM;
        it.perm_index   = idx;
        it.perm_value   = val;
        it.x_pos        = $urandom();
        it.z_pos        = $urandom();
        it.octave_count = 4'($urandom());
        return it;
    endfunction

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    endfunction

    initial begin
        t_in_item  it;
        logic [3:0] oct;
        board = new();
        board.load_identity();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity table, extremes, octave clamps, wrap on doubling
        send_beat(make_query(32'h0, 32'h0, 4'd1), 0);
        send_beat(make_query(32'h7FFF_FFFF, 32'h8000_0000, 4'd8), 0);
        send_beat(make_query(32'h8000_0000, 32'h7FFF_FFFF, 4'd0), 0);
        send_beat(make_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15), 0);
        send_beat(make_query(32'h0000_8000, 32'h0001_8000, 4'd9), 0);
        send_beat(make_query(32'h4000_FFFF, 32'hC000_0001, 4'd8), 2);
        send_beat(make_query(32'h00FF_0000, 32'h00FF_FFFF, 4'd2), 0);
        send_beat(make_write(8'd0, 8'd255), 0);
        send_beat(make_write(8'd255, 8'd0), 0);
        send_beat(make_write(8'd1, 8'd3), 0);
        send_beat(make_write(8'd170, 8'd85), 0);
        send_beat(make_query(32'h0000_C000, 32'hFFFF_4000, 4'd1), 0);
        send_beat(make_query(32'h00FF_8000, 32'h0000_8000, 4'd3), 1);
        send_beat(make_query(32'h1234_5678, 32'h9ABC_DEF0, 4'd8), 0);

        // random: mostly queries, with permutation rewrites mixed in
        for (int n = 0; n < 1640; n++) begin
            if (n == 300) long_stall = 1'b1;
            if ($urandom_range(0, 4) == 0) begin
                it = make_write(8'($urandom()), 8'($urandom()));
            end else begin
                // small octave counts keep the run short; a few go large
                oct = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 3));
                it = make_query($urandom(), $urandom(), oct);
            end
            send_beat(it, (n >= 300 && n < 330) ? 0 : draw_gap());
        end
        in_ch.valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.pending.size() != 0) board.mismatches++;
        $display("%0d beats sent: %0d noise samples, %0d table writes; %0d samples checked",
                 beats_sent, queries_sent, perm_writes, board.samples_checked);
        if (board.mismatches == 0) begin
            $display("fractal_perlin_noise_2d_tb: clean");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("fractal_perlin_noise_2d_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
hdl/fpn_pkg.sv
hdl/fpn_stream_if.sv
hdl/fpn_ram.sv
hdl/fractal_perlin_noise_2d.sv
tb/sv/fractal_perlin_noise_2d_tb.sv
